// ===== src/roi_chain_propagation_core_defines.svh =====
// Assertion macros for the ROI chain propagation core.
// Included by the RTL files that carry assertions; needs clk and rst_n in scope.
`ifndef ROI_CHAIN_PROPAGATION_CORE_DEFINES_SVH
`define ROI_CHAIN_PROPAGATION_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RCP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rcp_pkg.sv =====
// Shared types, constants and saturation helpers of the ROI chain propagation core.
// No dependencies.
`default_nettype none

package rcp_pkg;

    localparam int COORD_W     = 32;
    localparam int SUM_W       = COORD_W + 2;
    localparam int COORD_LIMIT = 1073741824;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [PADDR_W-3:0] REG_DIRECTION = 1'b0;

    localparam logic DIR_BACKWARD = 1'b0;
    localparam logic DIR_FORWARD  = 1'b1;

    typedef struct packed {
        logic                      start_req;
        logic signed [COORD_W-1:0] start_x0;
        logic signed [COORD_W-1:0] start_y0;
        logic signed [COORD_W-1:0] start_x1;
        logic signed [COORD_W-1:0] start_y1;
        logic signed [COORD_W-1:0] reach_left;
        logic signed [COORD_W-1:0] reach_right;
        logic signed [COORD_W-1:0] reach_up;
        logic signed [COORD_W-1:0] reach_down;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x0;
        logic signed [COORD_W-1:0] out_y0;
        logic signed [COORD_W-1:0] out_x1;
        logic signed [COORD_W-1:0] out_y1;
        logic                      is_empty;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } rect_t;

    function automatic logic signed [SUM_W-1:0] sext(input logic signed [COORD_W-1:0] v);
        sext = {{(SUM_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [COORD_W-1:0] sat(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] r;
        if (v < -lim)
        begin
            r = -lim;
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        sat = r[COORD_W-1:0];
    endfunction

    function automatic logic rect_empty(input rect_t r);
        rect_empty = (r.x0 >= r.x1) || (r.y0 >= r.y1);
    endfunction

endpackage

`default_nettype wire

// ===== src/roi_chain_propagation_core.sv =====
// Top level of the ROI chain propagation core: handshake stages and rectangle state.
// Depends on rcp_pkg, rcp_cfg, rcp_step and roi_chain_propagation_core_defines.svh.
`default_nettype none
`include "roi_chain_propagation_core_defines.svh"

// Takes one dilate-and-translate operation per transaction and returns the held
// rectangle after it. Throughput is one transaction per clock unless a stalled,
// full result register holds the input register; a taken transaction waits in the
// input register, and the step then loads the result register, which offers the
// result until it is taken. The step from the input register through the
// translate and dilate saturation into the rectangle register sets this rate, as
// each operation needs the rectangle left by the one before. The result register
// lets a new transaction enter while an earlier result waits to be taken. Write
// the direction register only while no transaction is in flight.
module roi_chain_propagation_core #(
    parameter int COORD_LIMIT = rcp_pkg::COORD_LIMIT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire rcp_pkg::in_item_t           item,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output rcp_pkg::out_item_t               result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rcp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rcp_pkg::PDATA_W-1:0] pwdata,
    output logic      [rcp_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    logic               direction;
    logic               in_valid_reg;
    logic               in_valid_next;
    rcp_pkg::in_item_t  in_item_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    rcp_pkg::out_item_t result_reg;
    rcp_pkg::rect_t     cur_rect_reg;
    rcp_pkg::rect_t     step_rect;
    logic               step_empty;
    logic               out_free;
    logic               fire;
    logic               take;

    rcp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .direction (direction)
    );

    rcp_step #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_step (
        .direction (direction),
        .item      (in_item_reg),
        .cur       (cur_rect_reg),
        .nxt       (step_rect),
        .nxt_empty (step_empty)
    );

    assign out_free   = !result_valid_reg || !result_stall;
    assign fire       = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            cur_rect_reg     <= '0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
            if (fire)
            begin
                cur_rect_reg <= step_rect;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= item;
        end
        if (fire)
        begin
            result_reg.out_x0   <= step_rect.x0;
            result_reg.out_y0   <= step_rect.y0;
            result_reg.out_x1   <= step_rect.x1;
            result_reg.out_y1   <= step_rect.y1;
            result_reg.is_empty <= step_empty;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `RCP_ASSERT_IMPL(a_empty_is_zero, result_valid && result.is_empty,
        result.out_x0 == 0 && result.out_y0 == 0 && result.out_x1 == 0 && result.out_y1 == 0,
        "empty result is not the all-zero rectangle")
    `RCP_ASSERT_IMPL(a_nonempty_ordered, result_valid && !result.is_empty,
        result.out_x0 < result.out_x1 && result.out_y0 < result.out_y1,
        "non-empty result has crossed edges")
    `RCP_ASSERT_IMPL(a_state_matches_result, result_valid,
        cur_rect_reg.x0 == result.out_x0 && cur_rect_reg.y0 == result.out_y0
        && cur_rect_reg.x1 == result.out_x1 && cur_rect_reg.y1 == result.out_y1,
        "held rectangle differs from the last result")
    `RCP_ASSERT_NEXT(a_fire_gives_result, fire, result_valid,
        "stepped transaction produced no result")
    `RCP_ASSERT_IMPL(a_stall_only_when_full, item_stall,
        in_valid_reg && result_valid_reg && result_stall,
        "input stalled while a stage is free")

endmodule

`default_nettype wire

// ===== src/rcp_cfg.sv =====
// APB register file of the ROI chain propagation core: the direction register.
// Depends on rcp_pkg.
`default_nettype none

module rcp_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rcp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rcp_pkg::PDATA_W-1:0] pwdata,
    output logic      [rcp_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output logic                             direction
);

    logic direction_reg;
    logic direction_next;
    logic wr_dir;

    assign pready = 1'b1;
    assign wr_dir = psel && penable && pwrite && pready
                    && (paddr[rcp_pkg::PADDR_W-1:2] == rcp_pkg::REG_DIRECTION);

    always_comb
    begin
        direction_next = direction_reg;
        if (wr_dir)
        begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= rcp_pkg::DIR_BACKWARD;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[rcp_pkg::PADDR_W-1:2] == rcp_pkg::REG_DIRECTION)
        begin
            prdata[0] = direction_reg;
        end
    end

    assign direction = direction_reg;

endmodule

`default_nettype wire

// ===== src/rcp_step.sv =====
// One translate-and-dilate step on the held rectangle or on the start rectangle of
// the item, with saturation and empty collapse. Depends on rcp_pkg.
`default_nettype none

module rcp_step #(
    parameter int COORD_LIMIT = rcp_pkg::COORD_LIMIT
) (
    input  wire logic              direction,
    input  wire rcp_pkg::in_item_t item,
    input  wire rcp_pkg::rect_t    cur,
    output rcp_pkg::rect_t         nxt,
    output logic                   nxt_empty
);

    localparam logic signed [rcp_pkg::SUM_W-1:0] LIM = rcp_pkg::SUM_W'(COORD_LIMIT);

    rcp_pkg::rect_t                     base;
    rcp_pkg::rect_t                     t;
    rcp_pkg::rect_t                     e;
    logic signed [rcp_pkg::SUM_W-1:0]   dx;
    logic signed [rcp_pkg::SUM_W-1:0]   dy;
    logic signed [rcp_pkg::COORD_W-1:0] lo_x;
    logic signed [rcp_pkg::COORD_W-1:0] hi_x;
    logic signed [rcp_pkg::COORD_W-1:0] lo_y;
    logic signed [rcp_pkg::COORD_W-1:0] hi_y;
    logic                               any_empty;

    always_comb
    begin
        if (item.start_req)
        begin
            base.x0 = item.start_x0;
            base.y0 = item.start_y0;
            base.x1 = item.start_x1;
            base.y1 = item.start_y1;
        end
        else
        begin
            base = cur;
        end

        if (direction == rcp_pkg::DIR_FORWARD)
        begin
            dx   = rcp_pkg::sext(item.shift_x);
            dy   = rcp_pkg::sext(item.shift_y);
            lo_x = item.reach_right;
            hi_x = item.reach_left;
            lo_y = item.reach_down;
            hi_y = item.reach_up;
        end
        else
        begin
            dx   = -rcp_pkg::sext(item.shift_x);
            dy   = -rcp_pkg::sext(item.shift_y);
            lo_x = item.reach_left;
            hi_x = item.reach_right;
            lo_y = item.reach_up;
            hi_y = item.reach_down;
        end

        t.x0 = rcp_pkg::sat(rcp_pkg::sext(base.x0) + dx, LIM);
        t.y0 = rcp_pkg::sat(rcp_pkg::sext(base.y0) + dy, LIM);
        t.x1 = rcp_pkg::sat(rcp_pkg::sext(base.x1) + dx, LIM);
        t.y1 = rcp_pkg::sat(rcp_pkg::sext(base.y1) + dy, LIM);

        e.x0 = rcp_pkg::sat(rcp_pkg::sext(t.x0) - rcp_pkg::sext(lo_x), LIM);
        e.y0 = rcp_pkg::sat(rcp_pkg::sext(t.y0) - rcp_pkg::sext(lo_y), LIM);
        e.x1 = rcp_pkg::sat(rcp_pkg::sext(t.x1) + rcp_pkg::sext(hi_x), LIM);
        e.y1 = rcp_pkg::sat(rcp_pkg::sext(t.y1) + rcp_pkg::sext(hi_y), LIM);

        any_empty = rcp_pkg::rect_empty(base) || rcp_pkg::rect_empty(t)
                    || rcp_pkg::rect_empty(e);

        if (any_empty)
        begin
            nxt = '0;
        end
        else
        begin
            nxt = e;
        end
    end

    assign nxt_empty = any_empty;

endmodule

`default_nettype wire

// ===== sim/tb_roi_chain_propagation_core.sv =====
// Testbench for roi_chain_propagation_core: directed and random dilate/translate chains,
// checked against an in-bench rectangle tracker under random idling and back-pressure.
// Depends on rcp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_roi_chain_propagation_core;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  PHASE_ITEMS  = 250;
    localparam int  PHASE_COUNT  = 8;
    localparam longint L         = rcp_pkg::COORD_LIMIT;

    class roi_tracker;
        longint             held_x0, held_y0, held_x1, held_y1;
        logic               dir;
        rcp_pkg::out_item_t rect_q[$];
        int                 mismatches;

        function new();
            held_x0 = 0;
            held_y0 = 0;
            held_x1 = 0;
            held_y1 = 0;
            dir = rcp_pkg::DIR_BACKWARD;
            mismatches = 0;
        endfunction

        function void set_direction(logic d);
            dir = d;
        endfunction

        function int outstanding();
            return rect_q.size();
        endfunction

        function longint clamp_coord(longint v);
            if (v < -L)
                return -L;
            if (v > L)
                return L;
            return v;
        endfunction

        function void note_input(rcp_pkg::in_item_t op);
            longint             dx, dy, lo_x, hi_x, lo_y, hi_y;
            longint             tx0, ty0, tx1, ty1;
            longint             nx0, ny0, nx1, ny1;
            bit                 collapsed;
            rcp_pkg::out_item_t want;
            if (op.start_req)
            begin
                held_x0 = longint'($signed(op.start_x0));
                held_y0 = longint'($signed(op.start_y0));
                held_x1 = longint'($signed(op.start_x1));
                held_y1 = longint'($signed(op.start_y1));
            end
            if (dir == rcp_pkg::DIR_FORWARD)
            begin
                dx   = longint'($signed(op.shift_x));
                dy   = longint'($signed(op.shift_y));
                lo_x = longint'($signed(op.reach_right));
                hi_x = longint'($signed(op.reach_left));
                lo_y = longint'($signed(op.reach_down));
                hi_y = longint'($signed(op.reach_up));
            end
            else
            begin
                dx   = -longint'($signed(op.shift_x));
                dy   = -longint'($signed(op.shift_y));
                lo_x = longint'($signed(op.reach_left));
                hi_x = longint'($signed(op.reach_right));
                lo_y = longint'($signed(op.reach_up));
                hi_y = longint'($signed(op.reach_down));
            end
            collapsed = (held_x0 >= held_x1) || (held_y0 >= held_y1);
            tx0 = clamp_coord(held_x0 + dx);
            ty0 = clamp_coord(held_y0 + dy);
            tx1 = clamp_coord(held_x1 + dx);
            ty1 = clamp_coord(held_y1 + dy);
            collapsed = collapsed || (tx0 >= tx1) || (ty0 >= ty1);
            nx0 = clamp_coord(tx0 - lo_x);
            ny0 = clamp_coord(ty0 - lo_y);
            nx1 = clamp_coord(tx1 + hi_x);
            ny1 = clamp_coord(ty1 + hi_y);
            collapsed = collapsed || (nx0 >= nx1) || (ny0 >= ny1);
            if (collapsed)
            begin
                nx0 = 0;
                ny0 = 0;
                nx1 = 0;
                ny1 = 0;
            end
            held_x0 = nx0;
            held_y0 = ny0;
            held_x1 = nx1;
            held_y1 = ny1;
            want.out_x0   = nx0[31:0];
            want.out_y0   = ny0[31:0];
            want.out_x1   = nx1[31:0];
            want.out_y1   = ny1[31:0];
            want.is_empty = collapsed;
            rect_q.push_back(want);
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(rcp_pkg::out_item_t got);
            rcp_pkg::out_item_t want;
            if (rect_q.size() == 0)
            begin
                report("result transaction with no rectangle expected");
                return;
            end
            want = rect_q.pop_front();
            if (got.out_x0 !== want.out_x0)
                report($sformatf("x0 got %0d want %0d", got.out_x0, want.out_x0));
            if (got.out_y0 !== want.out_y0)
                report($sformatf("y0 got %0d want %0d", got.out_y0, want.out_y0));
            if (got.out_x1 !== want.out_x1)
                report($sformatf("x1 got %0d want %0d", got.out_x1, want.out_x1));
            if (got.out_y1 !== want.out_y1)
                report($sformatf("y1 got %0d want %0d", got.out_y1, want.out_y1));
            if (got.is_empty !== want.is_empty)
                report($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_stall;
    rcp_pkg::in_item_t            item = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    rcp_pkg::out_item_t           result;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [rcp_pkg::PADDR_W-1:0]  paddr = '0;
    logic [rcp_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [rcp_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    roi_tracker tracker = new();
    bit         idle_on = 1'b1;
    int         hold_requests = 0;
    int         cycles = 0;

    roi_chain_propagation_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [31:0] any_coord();
        return 32'(longint'($urandom_range(32'h8000_0000)) - L);
    endfunction

    function automatic logic signed [31:0] draw(int lo, int hi);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return lo + int'($urandom_range(hi - lo));
        if (pick < 90)
            return any_coord();
        case ($urandom_range(2))
            0: return 32'(-L);
            1: return 32'(L);
            default: return 32'sd0;
        endcase
    endfunction

    function automatic rcp_pkg::in_item_t make_op(logic s, longint x0, longint y0,
                                                  longint x1, longint y1, longint rl,
                                                  longint rr, longint ru, longint rd,
                                                  longint sx, longint sy);
        rcp_pkg::in_item_t op;
        op.start_req   = s;
        op.start_x0    = x0[31:0];
        op.start_y0    = y0[31:0];
        op.start_x1    = x1[31:0];
        op.start_y1    = y1[31:0];
        op.reach_left  = rl[31:0];
        op.reach_right = rr[31:0];
        op.reach_up    = ru[31:0];
        op.reach_down  = rd[31:0];
        op.shift_x     = sx[31:0];
        op.shift_y     = sy[31:0];
        return op;
    endfunction

    function automatic rcp_pkg::in_item_t random_op();
        rcp_pkg::in_item_t op;
        int unsigned       shape;
        longint            bx, by;
        op.start_req = ($urandom_range(99) < 15);
        shape = $urandom_range(99);
        bx = longint'($urandom_range(2000000)) - 1000000;
        by = longint'($urandom_range(2000000)) - 1000000;
        op.start_x0 = bx[31:0];
        op.start_y0 = by[31:0];
        op.start_x1 = 32'(bx + 1 + $urandom_range(4000));
        op.start_y1 = 32'(by + 1 + $urandom_range(4000));
        if (shape >= 80)
        begin
            op.start_x0 = any_coord();
            op.start_y0 = any_coord();
            op.start_x1 = any_coord();
            op.start_y1 = any_coord();
        end
        if (shape >= 94)
            op.start_x1 = op.start_x0;
        op.reach_left  = draw(-8, 64);
        op.reach_right = draw(-8, 64);
        op.reach_up    = draw(-8, 64);
        op.reach_down  = draw(-8, 64);
        op.shift_x     = draw(-2000, 2000);
        op.shift_y     = draw(-2000, 2000);
        return op;
    endfunction

    task automatic write_direction(input logic dir);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rcp_pkg::REG_DIRECTION, 2'b00};
        pwdata  <= {{(rcp_pkg::PDATA_W-1){1'b0}}, dir};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_direction(dir);
    endtask

    task automatic offer_op(input rcp_pkg::in_item_t op);
        while (idle_on && $urandom_range(99) < 27)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= op;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        tracker.note_input(op);
    endtask

    task automatic offer_directed();
        offer_op(make_op(1'b0, L, -L, L, -L, 3, 3, 3, 3, 1, 1));
        offer_op(make_op(1'b1, 0, 0, 10, 10, 1, 2, 3, 4, 5, -6));
        offer_op(make_op(1'b0, -L, L, -L, L, 0, 0, 0, 0, 0, 0));
        offer_op(make_op(1'b1, 100, 100, 200, 200, 0, 0, 0, 0, -L, -L));
        offer_op(make_op(1'b1, 100, 100, 200, 200, 0, 0, 0, 0, L, L));
        offer_op(make_op(1'b1, 0, 0, 10, 10, -6, -6, 0, 0, 0, 0));
        offer_op(make_op(1'b1, 5, 0, 5, 10, 1, 1, 1, 1, 0, 0));
        offer_op(make_op(1'b1, -L, -L, L, L, L, L, L, L, L, -L));
        offer_op(make_op(1'b0, 0, 0, 0, 0, -L, -L, -L, -L, 0, 0));
        offer_op(make_op(1'b1, -L, -L, -L, -L, -L, -L, -L, -L, -L, -L));
        offer_op(make_op(1'b1, L, L, L, L, L, L, L, L, L, L));
        offer_op(make_op(1'b1, -1, -1, 1, 1, L, -L, -L, L, 0, 0));
    endtask

    task automatic run_phase(input logic dir, input int count, input bit quiet,
                             input bit squeeze);
        write_direction(dir);
        idle_on = !quiet;
        if (squeeze)
            hold_requests <= hold_requests + 1;
        if (count == 0)
            offer_directed();
        else
            repeat (count) offer_op(random_op());
        item_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                tracker.check_result(result);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= idle_on && ($urandom_range(99) < 27);
            end
        end
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_phase(rcp_pkg::DIR_BACKWARD, 0, 1'b0, 1'b0);
        run_phase(rcp_pkg::DIR_FORWARD, 0, 1'b0, 1'b0);
        for (int p = 0; p < PHASE_COUNT; p++)
            run_phase((p % 2 == 0) ? rcp_pkg::DIR_BACKWARD : rcp_pkg::DIR_FORWARD,
                      PHASE_ITEMS, p == 3, p == 5);
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
